// ===== design/lennard_jones_pair_energy_defines.svh =====
// ----------------------------------------------------------------------------
// Lennard-Jones pair energy: assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef LENNARD_JONES_PAIR_ENERGY_DEFINES_SVH
`define LENNARD_JONES_PAIR_ENERGY_DEFINES_SVH

`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted
`define LJPE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property, also evaluated during reset
`define LJPE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LJPE_ASSERT(lbl, clk, rst_n, prop, msg)
`define LJPE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== design/ljpe_pkg.sv =====
// ----------------------------------------------------------------------------
// Lennard-Jones pair energy package
// Shared types and constants for the divider cells and the energy datapath.
// ----------------------------------------------------------------------------
package ljpe_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_SIGMA_SQ       = 2'd0;
    localparam logic [1:0] REG_CORE_RADIUS_SQ = 2'd1;
    localparam logic [1:0] REG_FOUR_EPSILON   = 2'd2;
    localparam logic [1:0] REG_CORE_MODE      = 2'd3;

    // Core modes
    localparam logic CORE_HARD   = 1'b0;
    localparam logic CORE_SMOOTH = 1'b1;

    localparam int DIV_CELLS = 64;

    localparam logic [63:0] ONE_Q32   = 64'h0000_0001_0000_0000;
    localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

    // One restoring-division lane: partial remainder, numerator/quotient
    // shift word and divisor
    typedef struct packed {
        logic [47:0] rem;
        logic [63:0] nq;
        logic [47:0] den;
    } ljpe_lane_t;

    // Per-item case flags
    typedef struct packed {
        logic hz;   // hard core, result is zero
        logic sm;   // smooth core, evaluate at h^2 and scale
        logic rz;   // zero divisor
        logic ovf;  // intermediate overflow
    } ljpe_flags_t;

    // Payload handed from cell to cell
    typedef struct packed {
        ljpe_flags_t flags;
        ljpe_lane_t  lane_q;   // sigma^2 / r^2 (h^2 inside a smooth core)
        ljpe_lane_t  lane_c;   // r^2 / h^2
    } ljpe_cell_t;

endpackage

// ===== design/ljpe_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One quotient bit of two restoring divisions per cell, registered.
// ----------------------------------------------------------------------------
module ljpe_div_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 valid_in,
    input  ljpe_pkg::ljpe_cell_t cell_in,
    output logic                 valid_out,
    output ljpe_pkg::ljpe_cell_t cell_out
);
    import ljpe_pkg::*;

    logic       valid_reg;
    ljpe_cell_t data_reg;
    ljpe_cell_t data_next;

    // Shift in the next numerator bit, subtract when it fits
    function automatic ljpe_lane_t lane_step(input ljpe_lane_t l);
        ljpe_lane_t o;
        logic [48:0] t;
        logic        ge;
        t     = {l.rem, l.nq[63]};
        ge    = (t >= {1'b0, l.den});
        o.den = l.den;
        o.rem = ge ? 48'(t - {1'b0, l.den}) : t[47:0];
        o.nq  = {l.nq[62:0], ge};
        return o;
    endfunction

    always_comb begin
        data_next        = cell_in;
        data_next.lane_q = lane_step(cell_in.lane_q);
        data_next.lane_c = lane_step(cell_in.lane_c);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign cell_out  = data_reg;

endmodule

// ===== design/ljpe_mul.sv =====
// ----------------------------------------------------------------------------
// Fixed-point multiplier
// 64x64 product from four registered 32x32 partials, scaled down by SHIFT, registered.
// ----------------------------------------------------------------------------
module ljpe_mul #(
    parameter int SHIFT = 32
) (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] res,
    output logic        ovf
);
    logic [63:0]  ll_reg, lh_reg, hl_reg, hh_reg;
    logic [127:0] prod;
    logic [63:0]  res_reg;
    logic         ovf_reg;

    // Partial products
    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg <= a[31:0]  * b[31:0];
            lh_reg <= a[31:0]  * b[63:32];
            hl_reg <= a[63:32] * b[31:0];
            hh_reg <= a[63:32] * b[63:32];
        end
    end

    // Recombine, scale, flag bits above the result
    assign prod = {hh_reg, 64'd0} + {32'd0, lh_reg, 32'd0} + {32'd0, hl_reg, 32'd0}
                + {64'd0, ll_reg};

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= prod[SHIFT+63:SHIFT];
            ovf_reg <= |prod[127:SHIFT+64];
        end
    end

    assign res = res_reg;
    assign ovf = ovf_reg;

endmodule

// ===== design/lennard_jones_pair_energy.sv =====
// ----------------------------------------------------------------------------
// Lennard-Jones 12-6 pair energy
// Pipeline: 3 front stages, 64 divider cells, 13 multiply/select stages and
// the output register from input transaction to result valid.
// Throughput: one transaction per cycle while the two-deep output buffer has room.
// Reset: synchronous active-low aresetn clears valids and loads register defaults.
// ----------------------------------------------------------------------------
`include "lennard_jones_pair_energy_defines.svh"

module lennard_jones_pair_energy (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_wdata,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // coord_x[23:0], coord_y[47:24], coord_z[71:48]
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // energy[63:0]
    output logic        m_tuser    // saturated[0]
);
    import ljpe_pkg::*;

    typedef struct packed {
        ljpe_flags_t flags;
        logic        sneg;
        logic        lneg;
        logic        lsat;
        logic        sat;
        logic [63:0] q;
        logic [63:0] s;
        logic [63:0] d;
        logic [63:0] f;
        logic [63:0] mag;
        logic [63:0] energy;
    } post_t;

    localparam int POST_STAGES = 13;

    // Configuration registers
    logic [47:0] sigma_sq_reg;
    logic [47:0] core_radius_sq_reg;
    logic [31:0] four_epsilon_reg;
    logic        core_mode_reg;

    logic        en;
    logic        eps_neg;
    logic [31:0] eps_mag;

    logic        v1_reg, v2_reg, v3_reg;
    logic [47:0] sq_x_reg, sq_y_reg, sq_z_reg;
    logic [47:0] r2_reg;
    logic [47:0] rr;
    ljpe_cell_t  head_reg, head_next;

    logic        chain_valid [0:DIV_CELLS];
    ljpe_cell_t  chain       [0:DIV_CELLS];

    logic        pipe_valid_reg [1:POST_STAGES];
    post_t       pipe_reg       [1:POST_STAGES];
    post_t       post_next      [1:POST_STAGES];

    logic [63:0] qq_res, cc_res, s_res, p_res, v_res, sm_res;
    logic        qq_ovf, cc_ovf, s_ovf, p_ovf, v_ovf, sm_ovf;

    logic        out_valid_reg, skid_valid_reg;
    logic [63:0] out_energy_reg, skid_energy_reg;
    logic        out_sat_reg, skid_sat_reg;
    logic        push, pop;

    function automatic logic [23:0] coord_mag(input logic [23:0] c);
        return c[23] ? 24'(24'd0 - c) : c;
    endfunction

    // ---------------- configuration port ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sigma_sq_reg       <= 48'h00_0001_00_0000;
            core_radius_sq_reg <= 48'd0;
            four_epsilon_reg   <= 32'h0004_0000;
            core_mode_reg      <= CORE_HARD;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_SIGMA_SQ:       sigma_sq_reg       <= cfg_wdata;
                REG_CORE_RADIUS_SQ: core_radius_sq_reg <= cfg_wdata;
                REG_FOUR_EPSILON:   four_epsilon_reg   <= cfg_wdata[31:0];
                REG_CORE_MODE:      core_mode_reg      <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign eps_neg = four_epsilon_reg[31];
    assign eps_mag = eps_neg ? 32'(32'd0 - four_epsilon_reg) : four_epsilon_reg;

    // Pipeline advances while the skid slot is free
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // ---------------- front end: squares, r^2, case setup ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_x_reg <= coord_mag(s_tdata[23:0])  * coord_mag(s_tdata[23:0]);
            sq_y_reg <= coord_mag(s_tdata[47:24]) * coord_mag(s_tdata[47:24]);
            sq_z_reg <= coord_mag(s_tdata[71:48]) * coord_mag(s_tdata[71:48]);
            r2_reg   <= sq_x_reg + sq_y_reg + sq_z_reg;
            head_reg <= head_next;
        end
    end

    // Evaluation point is h^2 inside a smooth core, r^2 otherwise
    always_comb begin
        head_next.flags.hz  = (core_mode_reg == CORE_HARD) && (r2_reg <= core_radius_sq_reg);
        head_next.flags.sm  = (core_mode_reg == CORE_SMOOTH) && (r2_reg < core_radius_sq_reg);
        rr                  = head_next.flags.sm ? core_radius_sq_reg : r2_reg;
        head_next.flags.rz  = (rr == 48'd0);
        head_next.flags.ovf = ({32'd0, sigma_sq_reg[47:32]} >= rr);
        head_next.lane_q.rem = {32'd0, sigma_sq_reg[47:32]};
        head_next.lane_q.nq  = {sigma_sq_reg[31:0], 32'd0};
        head_next.lane_q.den = rr;
        head_next.lane_c.rem = {32'd0, r2_reg[47:32]};
        head_next.lane_c.nq  = {r2_reg[31:0], 32'd0};
        head_next.lane_c.den = core_radius_sq_reg;
    end

    // ---------------- divider cell chain ----------------
    assign chain_valid[0] = v3_reg;
    assign chain[0]       = head_reg;

    for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
        ljpe_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (chain_valid[i]),
            .cell_in   (chain[i]),
            .valid_out (chain_valid[i+1]),
            .cell_out  (chain[i+1])
        );
    end

    // ---------------- multipliers ----------------
    // q^2 and c^2 alongside the chain output
    ljpe_mul #(.SHIFT(32)) u_mul_qq (
        .aclk(aclk), .en(en), .a(chain[DIV_CELLS].lane_q.nq), .b(chain[DIV_CELLS].lane_q.nq),
        .res(qq_res), .ovf(qq_ovf)
    );
    ljpe_mul #(.SHIFT(32)) u_mul_cc (
        .aclk(aclk), .en(en), .a(chain[DIV_CELLS].lane_c.nq), .b(chain[DIV_CELLS].lane_c.nq),
        .res(cc_res), .ovf(cc_ovf)
    );
    // s = q^3
    ljpe_mul #(.SHIFT(32)) u_mul_s (
        .aclk(aclk), .en(en), .a(qq_res), .b(pipe_reg[2].q),
        .res(s_res), .ovf(s_ovf)
    );
    // p = s * |s - 1|
    ljpe_mul #(.SHIFT(32)) u_mul_p (
        .aclk(aclk), .en(en), .a(pipe_reg[5].s), .b(pipe_reg[5].d),
        .res(p_res), .ovf(p_ovf)
    );
    // |4 eps| * p, Q15.16 scale
    ljpe_mul #(.SHIFT(16)) u_mul_v (
        .aclk(aclk), .en(en), .a({32'd0, eps_mag}), .b(p_res),
        .res(v_res), .ovf(v_ovf)
    );
    // smooth-core scaling U(h^2) * (r^2/h^2)^2, cannot overflow
    ljpe_mul #(.SHIFT(32)) u_mul_sm (
        .aclk(aclk), .en(en), .a(pipe_reg[10].mag), .b(pipe_reg[10].f),
        .res(sm_res), .ovf(sm_ovf)
    );

    // ---------------- post stages ----------------
    always_comb begin
        logic        n;
        logic [63:0] lim;
        logic [63:0] m;

        post_next[1]       = '0;
        post_next[1].flags = chain[DIV_CELLS].flags;
        post_next[1].q     = chain[DIV_CELLS].lane_q.nq;
        for (int k = 2; k <= POST_STAGES; k++) begin
            post_next[k] = pipe_reg[k-1];
        end

        // q^2 overflow, c^2 ready
        post_next[3].flags.ovf = pipe_reg[2].flags.ovf | qq_ovf;
        post_next[3].f         = cc_res;

        // s and its distance from one
        post_next[5].s         = s_res;
        post_next[5].flags.ovf = pipe_reg[4].flags.ovf | s_ovf;
        post_next[5].sneg      = (s_res < ONE_Q32);
        post_next[5].d         = (s_res < ONE_Q32) ? ONE_Q32 - s_res : s_res - ONE_Q32;

        post_next[8].flags.ovf = pipe_reg[7].flags.ovf | p_ovf;

        // Energy at the evaluation point, sign and magnitude
        n   = eps_neg ^ pipe_reg[9].sneg;
        lim = n ? NEG_LIMIT : POS_LIMIT;
        if (pipe_reg[9].flags.rz || pipe_reg[9].flags.ovf) begin
            post_next[10].lneg = eps_neg;
            post_next[10].mag  = (eps_mag == 32'd0) ? 64'd0
                                 : (eps_neg ? NEG_LIMIT : POS_LIMIT);
            post_next[10].lsat = 1'b1;
        end else if (v_ovf || (v_res > lim)) begin
            post_next[10].lneg = n;
            post_next[10].mag  = lim;
            post_next[10].lsat = 1'b1;
        end else begin
            post_next[10].lneg = n && (v_res != 64'd0);
            post_next[10].mag  = v_res;
            post_next[10].lsat = 1'b0;
        end

        // Case selection and final sign
        if (pipe_reg[12].flags.sm) begin
            m = sm_res;
        end else begin
            m = pipe_reg[12].mag;
        end
        n = pipe_reg[12].lneg && (m != 64'd0);
        if (pipe_reg[12].flags.hz) begin
            post_next[13].energy = 64'd0;
            post_next[13].sat    = 1'b0;
        end else begin
            post_next[13].energy = n ? 64'd0 - m : m;
            post_next[13].sat    = pipe_reg[12].lsat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= POST_STAGES; k++) begin
                pipe_valid_reg[k] <= 1'b0;
            end
        end else if (en) begin
            pipe_valid_reg[1] <= chain_valid[DIV_CELLS];
            for (int k = 2; k <= POST_STAGES; k++) begin
                pipe_valid_reg[k] <= pipe_valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 1; k <= POST_STAGES; k++) begin
                pipe_reg[k] <= post_next[k];
            end
        end
    end

    // ---------------- output register with skid slot ----------------
    assign pop  = out_valid_reg && m_tready;
    assign push = en && pipe_valid_reg[POST_STAGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_energy_reg <= skid_energy_reg;
                out_sat_reg    <= skid_sat_reg;
            end else begin
                out_energy_reg <= pipe_reg[POST_STAGES].energy;
                out_sat_reg    <= pipe_reg[POST_STAGES].sat;
            end
        end else if (push) begin
            skid_energy_reg <= pipe_reg[POST_STAGES].energy;
            skid_sat_reg    <= pipe_reg[POST_STAGES].sat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_energy_reg;
    assign m_tuser  = out_sat_reg;

    // ---------------- assertions ----------------
    `LJPE_ASSERT(a_skid_has_head, aclk, aresetn, skid_valid_reg |-> out_valid_reg, "skid slot filled while output register empty")
    `LJPE_ASSERT(a_skid_on_stall, aclk, aresetn, $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready), "skid slot filled without an output stall")
    `LJPE_ASSERT(a_hard_core_zero, aclk, aresetn, (pipe_valid_reg[POST_STAGES] && pipe_reg[POST_STAGES].flags.hz) |-> (pipe_reg[POST_STAGES].energy == 64'd0 && !pipe_reg[POST_STAGES].sat), "hard core result not zero")
    `LJPE_ASSERT(a_zero_div_sat, aclk, aresetn, (pipe_valid_reg[10] && pipe_reg[10].flags.rz) |-> pipe_reg[10].lsat, "zero divisor without saturation flag")
    `LJPE_ASSERT(a_core_ratio_fits, aclk, aresetn, (pipe_valid_reg[2] && pipe_reg[2].flags.sm) |-> !cc_ovf, "core ratio square overflowed")
    `LJPE_ASSERT(a_core_scale_fits, aclk, aresetn, (pipe_valid_reg[12] && pipe_reg[12].flags.sm) |-> !sm_ovf, "smooth core scaling overflowed")

endmodule
